// ----- hdl/sbm_pkg.sv -----
`default_nettype none

package sbm_pkg;

    localparam int QUEUE_DEPTH = 2;

    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 5;
    localparam int S_TDATA_W   = 32;
    localparam int M_TDATA_W   = 24;

    localparam logic [CFG_IDX_W-1:0] CFG_PRG_BANK_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CHR_WRITABLE   = 2'd1;

    localparam logic [4:0] PRG_BANK_COUNT_RST = 5'd16;

    localparam logic [2:0] TGT_NONE    = 3'd0;
    localparam logic [2:0] TGT_PRG_ROM = 3'd1;
    localparam logic [2:0] TGT_PRG_RAM = 3'd2;
    localparam logic [2:0] TGT_CHR     = 3'd3;
    localparam logic [2:0] TGT_NT      = 3'd4;

    localparam logic [1:0] PRG_MODE_32K       = 2'd0;
    localparam logic [1:0] PRG_MODE_FIX_FIRST = 2'd1;
    localparam logic [1:0] PRG_MODE_FIX_LAST  = 2'd2;

    localparam logic [1:0] MIRROR_ONE_LOWER  = 2'd0;
    localparam logic [1:0] MIRROR_ONE_UPPER  = 2'd1;
    localparam logic [1:0] MIRROR_VERTICAL   = 2'd2;
    localparam logic [1:0] MIRROR_HORIZONTAL = 2'd3;

    localparam logic [1:0] SREG_CONTROL  = 2'd0;
    localparam logic [1:0] SREG_CHR_LOW  = 2'd1;
    localparam logic [1:0] SREG_CHR_HIGH = 2'd2;
    localparam logic [1:0] SREG_PRG      = 2'd3;

    localparam logic [4:0] SHIFT_EMPTY = 5'b10000;
    localparam logic [2:0] SHIFT_LAST  = 3'd5;

    typedef enum logic [2:0] {
        KIND_NONE,
        KIND_PRG_RAM,
        KIND_PRG_ROM,
        KIND_SERIAL,
        KIND_CHR,
        KIND_NT
    } sbm_kind_t;

    typedef struct packed {
        sbm_kind_t   kind;
        logic        wr;
        logic [15:0] addr;
        logic [7:0]  data;
    } sbm_req_t;

endpackage

`default_nettype wire

// ----- hdl/sbm_front.sv -----
`default_nettype none

module sbm_front (
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [31:0]           s_tdata,   // op[1:0], bus_addr[17:2], wdata[25:18]
    input  wire logic                  chr_writable,
    input  wire logic                  q_full,
    output logic                       q_push,
    output sbm_pkg::sbm_req_t          q_req
);
    import sbm_pkg::*;

    logic [1:0]  op;
    logic [15:0] addr;
    logic [7:0]  wdata;

    assign op    = s_tdata[1:0];
    assign addr  = s_tdata[17:2];
    assign wdata = s_tdata[25:18];

    assign s_tready = !q_full;
    assign q_push   = s_tvalid && !q_full;

    always_comb begin
        q_req.kind = KIND_NONE;
        q_req.wr   = 1'b0;
        q_req.addr = addr;
        q_req.data = wdata;
        if (!op[1]) begin
            if (addr[15:13] == 3'b011) begin
                q_req.kind = KIND_PRG_RAM;
                q_req.wr   = op[0];
            end else if (addr[15]) begin
                q_req.kind = op[0] ? KIND_SERIAL : KIND_PRG_ROM;
            end
        end else begin
            if (addr[15:13] == 3'b000) begin
                if (!op[0] || chr_writable) begin
                    q_req.kind = KIND_CHR;
                    q_req.wr   = op[0];
                end
            end else if (addr[15:12] == 4'h2) begin
                q_req.kind = KIND_NT;
                q_req.wr   = op[0];
            end
        end
    end

endmodule

`default_nettype wire

// ----- hdl/sbm_queue.sv -----
`default_nettype none

module sbm_queue #(
    parameter int DEPTH = sbm_pkg::QUEUE_DEPTH
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              push,
    input  wire sbm_pkg::sbm_req_t push_req,
    output logic                   full,
    input  wire logic              pop,
    output logic                   empty,
    output sbm_pkg::sbm_req_t      head_req
);
    import sbm_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    sbm_req_t          entry_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;

    assign full     = (count_reg == CNT_FULL);
    assign empty    = (count_reg == '0);
    assign head_req = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_req;
        end
    end

endmodule

`default_nettype wire

// ----- hdl/sbm_back.sv -----
`default_nettype none

module sbm_back (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic [4:0]        prg_bank_count,
    input  wire logic              q_empty,
    input  wire sbm_pkg::sbm_req_t q_req,
    output logic                   q_pop,
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic [23:0]            m_tdata    // target[2:0], phys_addr[20:3], write_strobe[21]
);
    import sbm_pkg::*;

    logic [4:0]  shift_reg, shift_next;
    logic [2:0]  count_reg, count_next;
    logic [1:0]  mirror_reg, mirror_next;
    logic [1:0]  prg_mode_reg, prg_mode_next;
    logic        chr_split_reg, chr_split_next;
    logic [4:0]  chr_low_reg, chr_low_next;
    logic [4:0]  chr_high_reg, chr_high_next;
    logic [3:0]  prg_sel_reg, prg_sel_next;

    logic        valid_reg;
    logic [2:0]  target_reg, target_next;
    logic [17:0] phys_reg, phys_next;
    logic        strobe_reg, strobe_next;

    logic [15:0] a;
    logic [3:0]  last_bank;
    logic [17:0] prg_rom_addr;
    logic [17:0] chr_addr;
    logic [17:0] nt_addr;
    logic        nt_page;
    logic [2:0]  count_inc;
    logic [4:0]  shift_in;

    assign a         = q_req.addr;
    assign q_pop     = !q_empty && (!valid_reg || m_tready);
    assign m_tvalid  = valid_reg;
    assign m_tdata   = {2'b00, strobe_reg, phys_reg, target_reg};
    assign last_bank = prg_bank_count[3:0] - 4'd1;
    assign count_inc = count_reg + 3'd1;
    assign shift_in  = {q_req.data[0], shift_reg[4:1]};

    always_comb begin
        case (prg_mode_reg)
            PRG_MODE_FIX_FIRST: prg_rom_addr = a[14] ? {prg_sel_reg, a[13:0]}
                                                     : {4'd0, a[13:0]};
            PRG_MODE_FIX_LAST:  prg_rom_addr = a[14] ? {last_bank, a[13:0]}
                                                     : {prg_sel_reg, a[13:0]};
            default:            prg_rom_addr = {prg_sel_reg[3:1], a[14:0]};
        endcase
    end

    always_comb begin
        if (chr_split_reg) begin
            chr_addr = {1'b0, (a[12] ? chr_high_reg : chr_low_reg), a[11:0]};
        end else begin
            chr_addr = {1'b0, chr_low_reg[4:1], a[12:0]};
        end
    end

    always_comb begin
        case (mirror_reg)
            MIRROR_ONE_LOWER: nt_page = 1'b0;
            MIRROR_ONE_UPPER: nt_page = 1'b1;
            MIRROR_VERTICAL:  nt_page = a[10];
            default:          nt_page = a[11];
        endcase
        nt_addr = {7'd0, nt_page, a[9:0]};
    end

    always_comb begin
        shift_next     = shift_reg;
        count_next     = count_reg;
        mirror_next    = mirror_reg;
        prg_mode_next  = prg_mode_reg;
        chr_split_next = chr_split_reg;
        chr_low_next   = chr_low_reg;
        chr_high_next  = chr_high_reg;
        prg_sel_next   = prg_sel_reg;
        target_next    = TGT_NONE;
        phys_next      = '0;
        strobe_next    = q_req.wr;
        case (q_req.kind)
            KIND_PRG_RAM: begin
                target_next = TGT_PRG_RAM;
                phys_next   = {5'd0, a[12:0]};
            end
            KIND_PRG_ROM: begin
                target_next = TGT_PRG_ROM;
                phys_next   = prg_rom_addr;
            end
            KIND_CHR: begin
                target_next = TGT_CHR;
                phys_next   = chr_addr;
            end
            KIND_NT: begin
                target_next = TGT_NT;
                phys_next   = nt_addr;
            end
            KIND_SERIAL: begin
                strobe_next = 1'b0;
                if (q_req.data[7]) begin
                    shift_next = SHIFT_EMPTY;
                    count_next = '0;
                end else if (count_inc == SHIFT_LAST) begin
                    shift_next = SHIFT_EMPTY;
                    count_next = '0;
                    case (a[14:13])
                        SREG_CONTROL: begin
                            mirror_next    = shift_in[1:0];
                            prg_mode_next  = !shift_in[3] ? PRG_MODE_32K :
                                             shift_in[2]  ? PRG_MODE_FIX_LAST
                                                          : PRG_MODE_FIX_FIRST;
                            chr_split_next = shift_in[4];
                        end
                        SREG_CHR_LOW:  chr_low_next  = shift_in;
                        SREG_CHR_HIGH: chr_high_next = shift_in;
                        SREG_PRG:      prg_sel_next  = shift_in[3:0];
                        default:       prg_sel_next  = prg_sel_reg;
                    endcase
                end else begin
                    shift_next = shift_in;
                    count_next = count_inc;
                end
            end
            default: begin
                strobe_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            shift_reg     <= '0;
            count_reg     <= '0;
            mirror_reg    <= MIRROR_ONE_LOWER;
            prg_mode_reg  <= PRG_MODE_32K;
            chr_split_reg <= 1'b0;
            chr_low_reg   <= '0;
            chr_high_reg  <= '0;
            prg_sel_reg   <= '0;
            valid_reg     <= 1'b0;
        end else begin
            if (q_pop) begin
                shift_reg     <= shift_next;
                count_reg     <= count_next;
                mirror_reg    <= mirror_next;
                prg_mode_reg  <= prg_mode_next;
                chr_split_reg <= chr_split_next;
                chr_low_reg   <= chr_low_next;
                chr_high_reg  <= chr_high_next;
                prg_sel_reg   <= prg_sel_next;
                valid_reg     <= 1'b1;
            end else if (m_tready) begin
                valid_reg     <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            target_reg <= target_next;
            phys_reg   <= phys_next;
            strobe_reg <= strobe_next;
        end
    end

endmodule

`default_nettype wire

// ----- hdl/serial_bank_mapper.sv -----
// serial_bank_mapper: bank-switching memory mapper with a five-bit serial
// configuration port.
// s_ channel: one CPU or PPU bus access per request. m_ channel: one result
// per request, in order: target memory, physical address, write strobe.
// CPU writes at 0x8000 and above go to the serial port and return target none.
// cfg_ port: cfg_addr 0 writes the program bank count, 1 the pattern RAM
// write enable; other indexes are ignored. Write only while idle.
// Requests pass the queue, then the output register. Throughput: one request
// per cycle unless stalled; the back end resolves one per cycle against the
// bank registers it alone updates, so accesses see serial writes in order.
// A QUEUE_DEPTH-entry queue lies between classifier and address generator.
// When the receiver stalls, the output register holds, the queue fills and
// s_tready falls once it is full.
// Reset (aresetn low, synchronous) empties queue and output register, clears
// all bank registers and sets the bank count to 16 with pattern RAM read-only.
`default_nettype none

module serial_bank_mapper #(
    parameter int QUEUE_DEPTH = sbm_pkg::QUEUE_DEPTH
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [sbm_pkg::S_TDATA_W-1:0] s_tdata,   // op[1:0], bus_addr[17:2], wdata[25:18]
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [sbm_pkg::M_TDATA_W-1:0]      m_tdata,   // target[2:0], phys_addr[20:3], write_strobe[21]
    input  wire logic                          cfg_wr_en,
    input  wire logic [sbm_pkg::CFG_IDX_W-1:0] cfg_addr,
    input  wire logic [sbm_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    import sbm_pkg::*;

    logic [4:0] bank_count_reg;
    logic       chr_wr_reg;
    logic       q_full;
    logic       q_empty;
    logic       q_push;
    logic       q_pop;
    sbm_req_t   push_req;
    sbm_req_t   head_req;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bank_count_reg <= PRG_BANK_COUNT_RST;
            chr_wr_reg     <= 1'b0;
        end else if (cfg_wr_en) begin
            if (cfg_addr == CFG_PRG_BANK_COUNT) begin
                bank_count_reg <= cfg_wdata[4:0];
            end else if (cfg_addr == CFG_CHR_WRITABLE) begin
                chr_wr_reg <= cfg_wdata[0];
            end
        end
    end

    sbm_front u_front (
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .chr_writable (chr_wr_reg),
        .q_full       (q_full),
        .q_push       (q_push),
        .q_req        (push_req)
    );

    sbm_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_req (push_req),
        .full     (q_full),
        .pop      (q_pop),
        .empty    (q_empty),
        .head_req (head_req)
    );

    sbm_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .prg_bank_count (bank_count_reg),
        .q_empty        (q_empty),
        .q_req          (head_req),
        .q_pop          (q_pop),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata)
    );

endmodule

`default_nettype wire
